### sv/utx_pkg.sv
// Shared types, codes and helpers for the Unicode transcoder.
package utx_pkg;

   typedef enum logic [1:0] {
      ENC_ASCII = 2'd0,
      ENC_UTF8  = 2'd1,
      ENC_UTF16 = 2'd2,
      ENC_UTF32 = 2'd3
   } enc_type;

   typedef enum logic [1:0] {
      JOB_CHAR = 2'd0,
      JOB_DONE = 2'd1,
      JOB_ERR  = 2'd2
   } job_kind_type;

   localparam logic [7:0] CSR_SOURCE = 8'd0;
   localparam logic [7:0] CSR_TARGET = 8'd1;

   localparam int UNIT_W  = 21;
   localparam int OUT_CNT_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam logic [20:0] SURR_LO   = 21'h00D800;
   localparam logic [20:0] SURR_HI   = 21'h00DFFF;
   localparam logic [20:0] LOW_SURR  = 21'h00DC00;
   localparam logic [20:0] SUPP_BASE = 21'h010000;
   localparam logic [20:0] CP_MAX    = 21'h10FFFF;
   localparam logic [20:0] ASCII_MAX = 21'h00007F;

   typedef struct packed {
      job_kind_type           kind;
      logic [UNIT_W-1:0]      cp;
      logic [OUT_CNT_W-1:0]   count;
   } job_type;

   function automatic logic bad_point(input logic [UNIT_W-1:0] cp);
      return (cp > CP_MAX) || ((cp >= SURR_LO) && (cp <= SURR_HI));
   endfunction

endpackage

### sv/utx_front.sv
// Front end: sequence assembly, validation and character counting.
module utx_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [31:0]         code_unit,
   input  utx_pkg::enc_type    source_enc,
   input  utx_pkg::enc_type    target_enc,
   input  logic                source_write,
   output logic                push,
   output utx_pkg::job_type    push_job
);

   logic [2:0]              expected_ff, expected_in;
   logic [2:0]              seen_ff, seen_in;
   logic [20:0]             accum_ff, accum_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    drop_ff, drop_in;

   logic        do_fail, fail_drop, do_finish;
   logic [20:0] fin_cp;
   logic [20:0] acc_cat;
   logic [2:0]  seen_inc;
   logic [20:0] min_cp;
   logic [63:0] count_ext;

   assign count_ext = 64'(count_ff);
   assign acc_cat   = {accum_ff[14:0], code_unit[5:0]};
   assign seen_inc  = seen_ff + 3'd1;

   always_comb begin
      case (expected_ff)
         3'd2:    min_cp = 21'h000080;
         3'd3:    min_cp = 21'h000800;
         default: min_cp = utx_pkg::SUPP_BASE;
      endcase
   end

   always_comb begin
      expected_in = expected_ff;
      seen_in     = seen_ff;
      accum_in    = accum_ff;
      count_in    = count_ff;
      drop_in     = drop_ff;
      push        = 1'b0;
      push_job    = '{kind: utx_pkg::JOB_CHAR, cp: '0, count: '0};
      do_fail     = 1'b0;
      fail_drop   = 1'b1;
      do_finish   = 1'b0;
      fin_cp      = code_unit[20:0];

      if (accept) begin
         if (code_unit == 32'd0) begin
            if (drop_ff) begin
               drop_in     = 1'b0;
               expected_in = '0;
               seen_in     = '0;
               accum_in    = '0;
               count_in    = '0;
            end else if (seen_ff != 3'd0) begin
               do_fail   = 1'b1;
               fail_drop = 1'b0;
            end else begin
               push     = 1'b1;
               push_job = '{kind: utx_pkg::JOB_DONE, cp: '0, count: count_ext[31:0]};
               count_in = '0;
            end
         end else if (!drop_ff) begin
            case (source_enc)
               utx_pkg::ENC_ASCII: begin
                  if (code_unit > 32'h7F) do_fail = 1'b1;
                  else do_finish = 1'b1;
               end
               utx_pkg::ENC_UTF8: begin
                  if (code_unit > 32'hFF) begin
                     do_fail = 1'b1;
                  end else if (seen_ff == 3'd0) begin
                     if (code_unit[7:0] <= 8'h7F) begin
                        do_finish = 1'b1;
                     end else if (code_unit[7:0] <= 8'hBF || code_unit[7:0] >= 8'hF8) begin
                        do_fail = 1'b1;
                     end else begin
                        seen_in = 3'd1;
                        if (code_unit[7:0] <= 8'hDF) begin
                           expected_in = 3'd2;
                           accum_in    = {16'd0, code_unit[4:0]};
                        end else if (code_unit[7:0] <= 8'hEF) begin
                           expected_in = 3'd3;
                           accum_in    = {17'd0, code_unit[3:0]};
                        end else begin
                           expected_in = 3'd4;
                           accum_in    = {18'd0, code_unit[2:0]};
                        end
                     end
                  end else if (code_unit[7:6] != 2'b10) begin
                     do_fail = 1'b1;
                  end else if (seen_inc < expected_ff) begin
                     accum_in = acc_cat;
                     seen_in  = seen_inc;
                  end else if (acc_cat < min_cp) begin
                     do_fail = 1'b1;
                  end else begin
                     do_finish = 1'b1;
                     fin_cp    = acc_cat;
                  end
               end
               utx_pkg::ENC_UTF16: begin
                  if (code_unit > 32'hFFFF) begin
                     do_fail = 1'b1;
                  end else if (seen_ff == 3'd0) begin
                     if (code_unit[15:10] == 6'b110110) begin
                        accum_in    = {11'd0, code_unit[9:0]};
                        expected_in = 3'd2;
                        seen_in     = 3'd1;
                     end else if (code_unit[15:10] == 6'b110111) begin
                        do_fail = 1'b1;
                     end else begin
                        do_finish = 1'b1;
                     end
                  end else if (code_unit[15:10] != 6'b110111) begin
                     do_fail = 1'b1;
                  end else begin
                     do_finish = 1'b1;
                     fin_cp    = {1'b0, accum_ff[9:0], code_unit[9:0]} + utx_pkg::SUPP_BASE;
                  end
               end
               default: begin
                  if (code_unit > 32'h0010FFFF) do_fail = 1'b1;
                  else do_finish = 1'b1;
               end
            endcase
         end
      end

      if (do_finish) begin
         expected_in = '0;
         seen_in     = '0;
         accum_in    = '0;
         if (utx_pkg::bad_point(fin_cp) ||
             (target_enc == utx_pkg::ENC_ASCII && fin_cp > utx_pkg::ASCII_MAX)) begin
            do_fail = 1'b1;
         end else begin
            push     = 1'b1;
            push_job = '{kind: utx_pkg::JOB_CHAR, cp: fin_cp, count: '0};
            count_in = count_ff + 1'b1;
         end
      end

      if (do_fail) begin
         push        = 1'b1;
         push_job    = '{kind: utx_pkg::JOB_ERR, cp: '0, count: count_ext[31:0]};
         count_in    = '0;
         expected_in = '0;
         seen_in     = '0;
         accum_in    = '0;
         drop_in     = fail_drop;
      end

      if (source_write) begin
         expected_in = '0;
         seen_in     = '0;
         accum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         seen_ff     <= '0;
         accum_ff    <= '0;
         count_ff    <= '0;
         drop_ff     <= 1'b0;
      end else begin
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         accum_ff    <= accum_in;
         count_ff    <= count_in;
         drop_ff     <= drop_in;
      end
   end

endmodule

### sv/utx_fifo.sv
// Short job queue between the front end and the encoder.
module utx_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  utx_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output utx_pkg::job_type head_job
);

   utx_pkg::job_type mem [utx_pkg::QUEUE_DEPTH];

   logic [utx_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [utx_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [utx_pkg::QUEUE_AW:0]   fill_ff, fill_in;

   assign full     = (fill_ff == (utx_pkg::QUEUE_AW+1)'(utx_pkg::QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign head_job = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### sv/utx_back.sv
// Back end: target encoding and registered result output.
module utx_back (
   input  logic             clock,
   input  logic             reset,
   input  utx_pkg::enc_type target_enc,
   input  logic             head_valid,
   input  utx_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [20:0] unit_ff, unit_in;
   logic [31:0] count_ff, count_in;
   logic        last_ff, last_in;
   logic [1:0]  user_ff, user_in;

   logic [20:0] units [4];
   logic [1:0]  last_idx;
   logic [20:0] cp;
   logic [20:0] supp;
   logic        load;

   assign cp   = head_job.cp;
   assign supp = cp - utx_pkg::SUPP_BASE;

   always_comb begin
      units[0] = cp;
      units[1] = '0;
      units[2] = '0;
      units[3] = '0;
      last_idx = 2'd0;
      if (head_job.kind == utx_pkg::JOB_CHAR) begin
         case (target_enc)
            utx_pkg::ENC_UTF8: begin
               if (cp <= 21'h7F) begin
                  units[0] = cp;
               end else if (cp <= 21'h7FF) begin
                  units[0] = {13'd0, 3'b110, cp[10:6]};
                  units[1] = {13'd0, 2'b10, cp[5:0]};
                  last_idx = 2'd1;
               end else if (cp <= 21'hFFFF) begin
                  units[0] = {13'd0, 4'b1110, cp[15:12]};
                  units[1] = {13'd0, 2'b10, cp[11:6]};
                  units[2] = {13'd0, 2'b10, cp[5:0]};
                  last_idx = 2'd2;
               end else begin
                  units[0] = {13'd0, 5'b11110, cp[20:18]};
                  units[1] = {13'd0, 2'b10, cp[17:12]};
                  units[2] = {13'd0, 2'b10, cp[11:6]};
                  units[3] = {13'd0, 2'b10, cp[5:0]};
                  last_idx = 2'd3;
               end
            end
            utx_pkg::ENC_UTF16: begin
               if (cp > 21'hFFFF) begin
                  units[0] = utx_pkg::SURR_LO  | {11'd0, supp[19:10]};
                  units[1] = utx_pkg::LOW_SURR | {11'd0, supp[9:0]};
                  last_idx = 2'd1;
               end
            end
            default: units[0] = cp;
         endcase
      end else begin
         units[0] = '0;
      end
   end

   assign load = head_valid && (!valid_ff || rsp_tready);
   assign pop  = load && (idx_ff == last_idx);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      unit_in  = unit_ff;
      count_in = count_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (load) begin
         valid_in = 1'b1;
         unit_in  = units[idx_ff];
         last_in  = (idx_ff == last_idx);
         count_in = (head_job.kind == utx_pkg::JOB_CHAR) ? 32'd0 : head_job.count;
         user_in  = {head_job.kind == utx_pkg::JOB_ERR, head_job.kind == utx_pkg::JOB_DONE};
         idx_in   = (idx_ff == last_idx) ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff  <= unit_in;
      count_ff <= count_in;
      last_ff  <= last_in;
      user_ff  <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, count_ff, unit_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

### sv/unicode_transcoder_unit.sv
// Unicode transcoder top level: config registers, front end, job queue, encoder.
// Path: a code unit is written into the job queue, then into the output register.
// Throughput: one code unit per cycle unless the four-entry job queue is full;
//   a character with n target units holds the encoder; the queue absorbs the burst.
// Reset: synchronous, active high; source UTF-8, target UTF-16, no partial
//   sequence, count zero, queue and output register empty.
module unicode_transcoder_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] code_unit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [20:0] out_unit, [52:21] char_count, rest zero
   output logic        rsp_tlast,   // char_end
   output logic [1:0]  rsp_tuser,   // [0] done_res, [1] error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [1:0]  csr_wdata
);

   utx_pkg::enc_type src_ff, src_in;
   utx_pkg::enc_type tgt_ff, tgt_in;

   logic             csr_write;
   logic             source_write;
   logic             accept;
   logic             push, pop, full, empty;
   utx_pkg::job_type push_job, head_job;

   assign csr_ready    = 1'b1;
   assign csr_write    = csr_valid && csr_ready;
   assign source_write = csr_write && (csr_index == utx_pkg::CSR_SOURCE);
   assign req_tready   = !full;
   assign accept       = req_tvalid && req_tready;

   always_comb begin
      src_in = src_ff;
      tgt_in = tgt_ff;
      if (source_write) src_in = utx_pkg::enc_type'(csr_wdata);
      if (csr_write && csr_index == utx_pkg::CSR_TARGET) tgt_in = utx_pkg::enc_type'(csr_wdata);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= utx_pkg::ENC_UTF8;
         tgt_ff <= utx_pkg::ENC_UTF16;
      end else begin
         src_ff <= src_in;
         tgt_ff <= tgt_in;
      end
   end

   utx_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .code_unit   (req_tdata),
      .source_enc  (src_ff),
      .target_enc  (tgt_ff),
      .source_write(source_write),
      .push        (push),
      .push_job    (push_job)
   );

   utx_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .full    (full),
      .empty   (empty),
      .head_job(head_job)
   );

   utx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .target_enc(tgt_ff),
      .head_valid(!empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule
